// ===== sv/uvs_pkg.sv =====
package uvs_pkg;

    // Parameter defaults
    localparam int DEF_MAX_STACKS = 512;
    localparam int DEF_MAX_SLICES = 1024;

    // Fixed field widths
    localparam int N_W      = 10;   // stack_count register
    localparam int S_W      = 11;   // slice_count register
    localparam int IDX_W    = 19;   // vertex index
    localparam int BASE_W   = 20;   // band base index
    localparam int REGION_W = 2;

    // Stream and register port widths
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 64;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Remainder unit: restoring steps per pipeline stage
    localparam int MOD_STEPS = 4;

    localparam logic [N_W-1:0] STACK_COUNT_RESET = 10'd16;
    localparam logic [S_W-1:0] SLICE_COUNT_RESET = 11'd32;

    // Register select (paddr[2])
    localparam logic REG_STACK_COUNT = 1'b0;
    localparam logic REG_SLICE_COUNT = 1'b1;

    typedef enum logic [REGION_W-1:0] {
        REGION_TOP = 2'd0,
        REGION_MID = 2'd1,
        REGION_BOT = 2'd2
    } region_t;

    typedef enum logic [2:0] {
        PH_TOP = 3'b001,
        PH_MID = 3'b010,
        PH_BOT = 3'b100
    } phase_t;

    // Per-triangle control carried down the pipe
    typedef struct packed {
        region_t region;
        logic    second_of_pair;
        logic    last_triangle;
    } ctl_t;

    // Effective configuration
    typedef struct packed {
        logic [N_W-1:0]   n;
        logic [S_W-1:0]   s;
        logic [IDX_W-1:0] lastv;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0]    corner_a;
        logic [IDX_W-1:0]    corner_b;
        logic [IDX_W-1:0]    corner_c;
        logic [REGION_W-1:0] region;
        logic                last_triangle;
    } result_t;

endpackage

// ===== sv/uvs_cfg.sv =====
module uvs_cfg #(
    parameter int MAX_STACKS = uvs_pkg::DEF_MAX_STACKS,
    parameter int MAX_SLICES = uvs_pkg::DEF_MAX_SLICES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [uvs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [uvs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [uvs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output uvs_pkg::cfg_t                   cfg
);
    import uvs_pkg::*;

    logic [N_W-1:0]       stack_count_reg;
    logic [S_W-1:0]       slice_count_reg;
    logic [IDX_W-1:0]     lastv_reg;
    logic [N_W-1:0]       n;
    logic [S_W-1:0]       s;
    logic [S_W+N_W-1:0]   prod;
    logic                 wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_count_reg <= STACK_COUNT_RESET;
            slice_count_reg <= SLICE_COUNT_RESET;
        end
        else if (wr)
        begin
            unique case (paddr[2])
                REG_STACK_COUNT: stack_count_reg <= pwdata[N_W-1:0];
                REG_SLICE_COUNT: slice_count_reg <= pwdata[S_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_STACK_COUNT: prdata = APB_DATA_W'(stack_count_reg);
            REG_SLICE_COUNT: prdata = APB_DATA_W'(slice_count_reg);
        endcase
    end

    // Saturate to the supported mesh sizes
    always_comb
    begin
        n = stack_count_reg;
        if (stack_count_reg < N_W'(2))
            n = N_W'(2);
        else if (int'(stack_count_reg) > MAX_STACKS)
            n = N_W'(MAX_STACKS);

        s = slice_count_reg;
        if (slice_count_reg < S_W'(3))
            s = S_W'(3);
        else if (int'(slice_count_reg) > MAX_SLICES)
            s = S_W'(MAX_SLICES);
    end

    // Bottom pole index 1 + s*(n-1); only read by items well after a write
    assign prod = s * (n - N_W'(1));

    always_ff @(posedge clk)
    begin
        lastv_reg <= IDX_W'(prod + (S_W+N_W)'(1));
    end

    assign cfg.n     = n;
    assign cfg.s     = s;
    assign cfg.lastv = lastv_reg;

endmodule

// ===== sv/uvs_seq.sv =====
module uvs_seq #(
    parameter int MAX_STACKS = uvs_pkg::DEF_MAX_STACKS,
    parameter int MAX_SLICES = uvs_pkg::DEF_MAX_SLICES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              en,
    input  logic                              restart,
    input  logic [uvs_pkg::N_W-1:0]           n,
    input  logic [uvs_pkg::S_W-1:0]           s,
    output logic                              snap_valid,
    output logic [$clog2(MAX_SLICES)-1:0]     snap_col,
    output logic [uvs_pkg::BASE_W-1:0]        snap_base,
    output uvs_pkg::ctl_t                     snap_ctl
);
    import uvs_pkg::*;

    localparam int COL_W  = $clog2(MAX_SLICES);
    localparam int BAND_W = $clog2(MAX_STACKS);
    localparam int CW     = (COL_W + 1 > S_W) ? COL_W + 1 : S_W;
    localparam int BW     = (BAND_W + 1 > N_W) ? BAND_W + 1 : N_W;

    phase_t              phase_reg, phase_e, phase_next;
    logic [BAND_W-1:0]   band_reg, band_e, band_next;
    logic [COL_W-1:0]    column_reg, column_e, column_next;
    logic                second_reg, second_e, second_next;
    logic [BASE_W-1:0]   base_reg, base_e, base_next;

    logic                snap_valid_reg;
    logic [COL_W-1:0]    snap_col_reg;
    logic [BASE_W-1:0]   snap_base_reg;
    ctl_t                snap_ctl_reg;
    ctl_t                ctl;

    logic [COL_W:0]      col1;
    logic [BAND_W:0]     band1;
    logic                col_end;
    logic                col_wrap;
    logic                band_done;
    logic                accept;

    assign accept = in_valid & en;

    // Restart rewinds before the triangle is chosen
    always_comb
    begin
        if (restart)
        begin
            phase_e  = PH_TOP;
            band_e   = '0;
            column_e = '0;
            second_e = 1'b0;
            base_e   = BASE_W'(1);
        end
        else
        begin
            phase_e  = phase_reg;
            band_e   = band_reg;
            column_e = column_reg;
            second_e = second_reg;
            base_e   = base_reg;
        end
    end

    assign col1      = {1'b0, column_e} + (COL_W+1)'(1);
    assign band1     = {1'b0, band_e} + (BAND_W+1)'(1);
    assign col_end   = CW'(column_e) >= CW'(s - S_W'(1));
    assign col_wrap  = CW'(col1) >= CW'(s);
    assign band_done = BW'(band1) >= BW'(n - N_W'(2));

    always_comb
    begin
        phase_next         = phase_e;
        band_next          = band_e;
        column_next        = column_e;
        second_next        = second_e;
        base_next          = base_e;
        ctl.region         = REGION_TOP;
        ctl.second_of_pair = second_e;
        ctl.last_triangle  = 1'b0;

        unique case (phase_e)
            PH_MID:
            begin
                ctl.region = REGION_MID;
                if (!second_e)
                    second_next = 1'b1;
                else
                begin
                    second_next = 1'b0;
                    if (col_wrap)
                    begin
                        column_next = '0;
                        band_next   = band1[BAND_W-1:0];
                        base_next   = base_e + BASE_W'(s);
                        if (band_done)
                            phase_next = PH_BOT;
                    end
                    else
                        column_next = col1[COL_W-1:0];
                end
            end
            PH_BOT:
            begin
                ctl.region = REGION_BOT;
                if (col_end)
                begin
                    ctl.last_triangle = 1'b1;
                    phase_next  = PH_TOP;
                    band_next   = '0;
                    column_next = '0;
                    second_next = 1'b0;
                    base_next   = BASE_W'(1);
                end
                else
                    column_next = col1[COL_W-1:0];
            end
            default:
            begin
                // top fan
                ctl.region = REGION_TOP;
                if (col_end)
                begin
                    column_next = '0;
                    second_next = 1'b0;
                    band_next   = '0;
                    base_next   = BASE_W'(1);
                    phase_next  = (n > N_W'(2)) ? PH_MID : PH_BOT;
                end
                else
                begin
                    column_next = col1[COL_W-1:0];
                    phase_next  = PH_TOP;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TOP;
            band_reg   <= '0;
            column_reg <= '0;
            second_reg <= 1'b0;
            base_reg   <= BASE_W'(1);
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            band_reg   <= band_next;
            column_reg <= column_next;
            second_reg <= second_next;
            base_reg   <= base_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            snap_valid_reg <= 1'b0;
        else if (en)
            snap_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            snap_col_reg  <= column_e;
            snap_base_reg <= base_e;
            snap_ctl_reg  <= ctl;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap_col   = snap_col_reg;
    assign snap_base  = snap_base_reg;
    assign snap_ctl   = snap_ctl_reg;

endmodule

// ===== sv/uvs_mod.sv =====
module uvs_mod #(
    parameter int X_W    = 11,
    parameter int D_W    = 11,
    parameter int SIDE_W = 8,
    parameter int STEPS  = uvs_pkg::MOD_STEPS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [X_W-1:0]    in_x,
    input  logic [D_W-1:0]    in_d,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [D_W-1:0]    out_rem,
    output logic [SIDE_W-1:0] out_side
);
    // Restoring remainder x % d, STEPS quotient bits per stage.
    // d must stay at or above 1 and must not change while items are in flight.
    localparam int NST   = (X_W + STEPS - 1) / STEPS;
    localparam int PAD_W = NST * STEPS;

    logic              vld_reg  [NST];
    logic [D_W-1:0]    rem_reg  [NST];
    logic [X_W-1:0]    x_reg    [NST];
    logic [SIDE_W-1:0] side_reg [NST];

    for (genvar k = 0; k < NST; k++)
    begin : g_stage
        logic              vin;
        logic [D_W-1:0]    rin;
        logic [X_W-1:0]    xin;
        logic [SIDE_W-1:0] sin;
        logic [PAD_W-1:0]  xpad;
        logic [D_W:0]      w;
        logic [D_W-1:0]    r;

        if (k == 0)
        begin : g_first
            assign vin = in_valid;
            assign rin = '0;
            assign xin = in_x;
            assign sin = in_side;
        end
        else
        begin : g_rest
            assign vin = vld_reg[k-1];
            assign rin = rem_reg[k-1];
            assign xin = x_reg[k-1];
            assign sin = side_reg[k-1];
        end

        // leading zero padding leaves the remainder unchanged
        always_comb
        begin
            xpad = PAD_W'(xin);
            r    = rin;
            w    = '0;
            for (int t = 0; t < STEPS; t++)
            begin
                w = {r, xpad[PAD_W-1-k*STEPS-t]};
                if (w >= {1'b0, in_d})
                    w = w - {1'b0, in_d};
                r = w[D_W-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vin;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= r;
                x_reg[k]    <= xin;
                side_reg[k] <= sin;
            end
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out_rem   = rem_reg[NST-1];
    assign out_side  = side_reg[NST-1];

endmodule

// ===== sv/uvs_emit.sv =====
module uvs_emit #(
    parameter int MAX_SLICES = uvs_pkg::DEF_MAX_SLICES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [$clog2(MAX_SLICES)-1:0]  col,
    input  logic [uvs_pkg::BASE_W-1:0]     base,
    input  uvs_pkg::ctl_t                  ctl,
    input  logic [uvs_pkg::S_W-1:0]        rem,
    input  uvs_pkg::cfg_t                  cfg,
    output logic                           out_valid,
    output uvs_pkg::result_t               result
);
    import uvs_pkg::*;

    localparam int COL_W = $clog2(MAX_SLICES);
    localparam int CW    = (COL_W > S_W) ? COL_W : S_W;

    logic [IDX_W-1:0] j19, r19, s19, base19, jm19;
    logic [IDX_W-1:0] v1, v2, v3, v4, ring;
    result_t          res;
    result_t          result_reg;
    logic             out_valid_reg;

    assign j19    = IDX_W'(col);
    assign r19    = IDX_W'(rem);
    assign s19    = IDX_W'(cfg.s);
    assign base19 = base[IDX_W-1:0];
    // column clipped to the last slice
    assign jm19   = (CW'(col) < CW'(cfg.s)) ? j19 : IDX_W'(cfg.s - S_W'(1));

    assign v1   = base19 + j19;
    assign v2   = base19 + r19;
    assign v3   = v1 + s19;
    assign v4   = v2 + s19;
    assign ring = cfg.lastv - s19;

    always_comb
    begin
        res.region        = ctl.region;
        res.last_triangle = ctl.last_triangle;
        case (ctl.region)
            REGION_MID:
            begin
                res.corner_a = v3;
                res.corner_b = ctl.second_of_pair ? v2 : v4;
                res.corner_c = ctl.second_of_pair ? v1 : v2;
            end
            REGION_BOT:
            begin
                res.corner_a = cfg.lastv;
                res.corner_b = ring + r19;
                res.corner_c = ring + jm19;
            end
            default:
            begin
                res.corner_a = '0;
                res.corner_b = jm19 + IDX_W'(1);
                res.corner_c = r19 + IDX_W'(1);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            result_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ===== sv/uv_sphere_triangle_index_sequencer_top.sv =====
// Path: a request accepted on s_tvalid passes the sequencer snapshot register, the
//   remainder stages and the emit output register before its triangle shows on m_tvalid.
// Throughput: one triangle per cycle unless m_tready stalls; counter next-state is comb.
// Reset (rst_n, async, active low): sequence rewinds to the first top-fan
//   triangle, stack_count = 16, slice_count = 32, pipeline emptied.
module uv_sphere_triangle_index_sequencer_top #(
    parameter int MAX_STACKS = uvs_pkg::DEF_MAX_STACKS,
    parameter int MAX_SLICES = uvs_pkg::DEF_MAX_SLICES
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // Request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [uvs_pkg::S_DATA_W-1:0]    s_tdata,   // [0] restart, rest zero

    // Triangle stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [uvs_pkg::M_DATA_W-1:0]    m_tdata,   // [18:0] corner_a, [37:19] corner_b,
                                                       // [56:38] corner_c, rest zero
    output logic [uvs_pkg::REGION_W-1:0]    m_tuser,   // [1:0] region
    output logic                            m_tlast,   // last_triangle

    // Register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [uvs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [uvs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [uvs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import uvs_pkg::*;

    localparam int COL_W  = $clog2(MAX_SLICES);
    localparam int CTL_W  = $bits(ctl_t);
    localparam int SIDE_W = CTL_W + BASE_W + COL_W;

    cfg_t              cfg;
    logic              en;

    logic              snap_valid;
    logic [COL_W-1:0]  snap_col;
    logic [BASE_W-1:0] snap_base;
    ctl_t              snap_ctl;

    logic [COL_W:0]    mod_x;
    logic [SIDE_W-1:0] mod_side_in;
    logic [SIDE_W-1:0] mod_side_out;
    logic              mod_valid;
    logic [S_W-1:0]    mod_rem;

    logic [COL_W-1:0]  e_col;
    logic [BASE_W-1:0] e_base;
    ctl_t              e_ctl;

    result_t           result;

    // Whole pipe moves together whenever the output slot frees up
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    uvs_cfg #(
        .MAX_STACKS (MAX_STACKS),
        .MAX_SLICES (MAX_SLICES)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stage 0: sequence counters, snapshot of the chosen triangle
    uvs_seq #(
        .MAX_STACKS (MAX_STACKS),
        .MAX_SLICES (MAX_SLICES)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .en         (en),
        .restart    (s_tdata[0]),
        .n          (cfg.n),
        .s          (cfg.s),
        .snap_valid (snap_valid),
        .snap_col   (snap_col),
        .snap_base  (snap_base),
        .snap_ctl   (snap_ctl)
    );

    // Neighbor column (column+1) mod slices; the column can sit past the
    // slice count after slice_count is lowered mid-mesh, so a true remainder.
    assign mod_x       = {1'b0, snap_col} + (COL_W+1)'(1);
    assign mod_side_in = {snap_ctl, snap_base, snap_col};

    uvs_mod #(
        .X_W    (COL_W + 1),
        .D_W    (S_W),
        .SIDE_W (SIDE_W),
        .STEPS  (MOD_STEPS)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (snap_valid),
        .in_x      (mod_x),
        .in_d      (cfg.s),
        .in_side   (mod_side_in),
        .out_valid (mod_valid),
        .out_rem   (mod_rem),
        .out_side  (mod_side_out)
    );

    assign e_col  = mod_side_out[COL_W-1:0];
    assign e_base = mod_side_out[COL_W +: BASE_W];
    assign e_ctl  = ctl_t'(mod_side_out[COL_W+BASE_W +: CTL_W]);

    // Final stage: vertex arithmetic into the output register
    uvs_emit #(
        .MAX_SLICES (MAX_SLICES)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mod_valid),
        .col       (e_col),
        .base      (e_base),
        .ctl       (e_ctl),
        .rem       (mod_rem),
        .cfg       (cfg),
        .out_valid (m_tvalid),
        .result    (result)
    );

    assign m_tdata = {(M_DATA_W - 3*IDX_W)'(0), result.corner_c, result.corner_b,
                      result.corner_a};
    assign m_tuser = result.region;
    assign m_tlast = result.last_triangle;

endmodule

// ===== bench/triangle_checker.sv =====
`timescale 1ns / 100ps

module triangle_checker
    import uvs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [S_DATA_W-1:0]     s_tdata,    // [0] restart

    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [M_DATA_W-1:0]     m_tdata,    // [18:0] a, [37:19] b, [56:38] c
    input  logic [REGION_W-1:0]     m_tuser,    // [1:0] region
    input  logic                    m_tlast,    // last_triangle

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    input  logic [APB_DATA_W-1:0]   prdata,
    input  logic                    pready,

    output int                      fail_count,
    output int                      pending,
    output int                      checked,
    output int                      meshes
);

    typedef struct packed {
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
        region_t          region;
        logic             last;
    } triangle_t;

    typedef enum logic [1:0] {
        SEQ_TOP,
        SEQ_MID,
        SEQ_BOT
    } seq_phase_t;

    localparam int MAX_N        = DEF_MAX_STACKS;
    localparam int MAX_S        = DEF_MAX_SLICES;
    localparam int EXPECT_DEPTH = 64;   // far more than the pipe can hold

    logic [N_W-1:0]    stack_reg;
    logic [S_W-1:0]    slice_reg;
    seq_phase_t        seq_phase;
    logic [8:0]        band;
    logic [9:0]        column;
    logic              second_half;
    logic [BASE_W-1:0] band_base;

    // Expected triangles in request order: written at wr_count, read at rd_count
    triangle_t expected_mem [EXPECT_DEPTH];
    int        wr_count;
    int        rd_count;

    assign pending = wr_count - rd_count;

    function automatic void rewind_mesh();
        seq_phase   = SEQ_TOP;
        band        = '0;
        column      = '0;
        second_half = 1'b0;
        band_base   = BASE_W'(1);
    endfunction

    // Next triangle of the mesh; advances the sequence counters.
    function automatic triangle_t next_triangle(input logic restart);
        triangle_t   t;
        int unsigned n, s, j, col, bnd, base;
        int unsigned v1, v2, v3, v4, lastv, ca, cb, cc;
        n = stack_reg;
        s = slice_reg;
        if (n < 2) n = 2;
        if (n > MAX_N) n = MAX_N;
        if (s < 3) s = 3;
        if (s > MAX_S) s = MAX_S;
        if (restart)
            rewind_mesh();
        col = column;
        bnd = band;
        base = band_base;
        j = col;
        t.last = 1'b0;
        case (seq_phase)
            SEQ_MID:
            begin
                v1 = base + j;
                v2 = base + ((j + 1) % s);
                v3 = v1 + s;
                v4 = v2 + s;
                t.region = REGION_MID;
                if (!second_half)
                begin
                    ca = v3; cb = v4; cc = v2;
                    second_half = 1'b1;
                end
                else
                begin
                    ca = v3; cb = v2; cc = v1;
                    second_half = 1'b0;
                    col++;
                    if (col >= s)
                    begin
                        col = 0;
                        bnd++;
                        base += s;
                        if (bnd >= n - 2)
                            seq_phase = SEQ_BOT;
                    end
                end
            end
            SEQ_BOT:
            begin
                lastv = 1 + s * (n - 1);
                t.region = REGION_BOT;
                ca = lastv;
                cb = lastv - s + ((j + 1) % s);
                cc = lastv - s + ((j < s) ? j : s - 1);
                if (col >= s - 1)
                begin
                    t.last = 1'b1;
                    rewind_mesh();
                    col = 0;
                    bnd = 0;
                    base = 1;
                end
                else
                    col++;
            end
            default:
            begin
                t.region = REGION_TOP;
                ca = 0;
                cb = ((j < s) ? j : s - 1) + 1;
                cc = ((j + 1) % s) + 1;
                if (col >= s - 1)
                begin
                    col = 0;
                    second_half = 1'b0;
                    bnd = 0;
                    base = 1;
                    seq_phase = (n > 2) ? SEQ_MID : SEQ_BOT;
                end
                else
                begin
                    col++;
                    seq_phase = SEQ_TOP;
                end
            end
        endcase
        band = bnd[8:0];
        column = col[9:0];
        band_base = base[BASE_W-1:0];
        t.a = ca[IDX_W-1:0];
        t.b = cb[IDX_W-1:0];
        t.c = cc[IDX_W-1:0];
        return t;
    endfunction

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        triangle_t want;
        logic [APB_DATA_W-1:0] reg_value;
        if (!rst_n)
        begin
            stack_reg = STACK_COUNT_RESET;
            slice_reg = SLICE_COUNT_RESET;
            rewind_mesh();
            wr_count = 0;
            rd_count = 0;
            fail_count = 0;
            checked = 0;
            meshes = 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[2] == REG_STACK_COUNT)
                        stack_reg = pwdata[N_W-1:0];
                    else
                        slice_reg = pwdata[S_W-1:0];
                end
                else
                begin
                    reg_value = (paddr[2] == REG_STACK_COUNT) ?
                                APB_DATA_W'(stack_reg) : APB_DATA_W'(slice_reg);
                    check_field("prdata", reg_value, prdata);
                end
            end
            // results first: a request taken at this edge cannot show yet
            if (m_tvalid && m_tready)
            begin
                if (wr_count == rd_count)
                begin
                    $display("%0t: triangle with none expected, expected none actual %h",
                             $time, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_mem[rd_count % EXPECT_DEPTH];
                    rd_count++;
                    check_field("corner_a", want.a, m_tdata[IDX_W-1:0]);
                    check_field("corner_b", want.b, m_tdata[2*IDX_W-1:IDX_W]);
                    check_field("corner_c", want.c, m_tdata[3*IDX_W-1:2*IDX_W]);
                    check_field("region", want.region, m_tuser);
                    check_field("last_triangle", want.last, m_tlast);
                    checked++;
                    if (want.last)
                        meshes++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_mem[wr_count % EXPECT_DEPTH] = next_triangle(s_tdata[0]);
                wr_count++;
            end
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import uvs_pkg::*;

    localparam int REQUEST_TOTAL  = 2000;
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
    localparam int SETTLE_CYCLES  = 8;     // more than the pipeline depth, for margin

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;       // [0] restart, rest zero

    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;            // [18:0] a, [37:19] b, [56:38] c
    logic [REGION_W-1:0]   m_tuser;            // [1:0] region
    logic                  m_tlast;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count, pending, checked, meshes;

    int requests_sent = 0;
    int settings_used = 0;
    int gap_pct = 0;        // chance of a sender gap before each request
    bit quiet = 1'b0;       // final stretch: no idling on either side
    int ready_hold = 0;
    int idle_cycles = 0;

    always #4 clk = ~clk;

    uv_sphere_triangle_index_sequencer_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    triangle_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .meshes     (meshes)
    );

    // Receiver back-pressure: ready runs mix with randomly drawn stall
    // bursts; held high once the final stretch begins and the current run ends.
    always @(posedge clk)
    begin
        if (ready_hold > 0)
            ready_hold--;
        else if (quiet || $urandom_range(0, 3) != 0)
        begin
            m_tready <= 1'b1;
            ready_hold = $urandom_range(0, 20);
        end
        else
        begin
            m_tready <= 1'b0;
            ready_hold = $urandom_range(0, 15);
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable))
            idle_cycles = 0;
        else if (++idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // One request; called right after a rising edge. A gap first drops tvalid,
    // otherwise tvalid stays high from the last request.
    task automatic send_request(input logic restart);
        if (!quiet && $urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-1){1'b0}}, restart};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        requests_sent++;
    endtask

    // Stop sending and let every outstanding triangle drain out.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup phase, access phase, then an idle phase with psel low so psel never gets
    // two updates in the same step across back-to-back calls.
    task automatic apb_access(input logic wr, input logic sel,
                              input logic [APB_DATA_W-1:0] wdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {sel, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Write a register, sometimes with junk above the field, and read it back.
    task automatic write_register(input logic sel, input int unsigned value,
                                  input int width);
        logic [APB_DATA_W-1:0] wdata;
        wdata = value;
        if ($urandom_range(0, 1))
            wdata = wdata | ($urandom << width);
        apb_access(1'b1, sel, wdata);
        apb_access(1'b0, sel, '0);
    endtask

    // Registers only change with the pipeline empty; the mesh counters
    // carry on, so a change mid-mesh exercises the "at or beyond" exits.
    task automatic configure(input bit set_n, input int unsigned n_val,
                             input bit set_s, input int unsigned s_val);
        drain();
        if (set_n)
            write_register(REG_STACK_COUNT, n_val, N_W);
        if (set_s)
            write_register(REG_SLICE_COUNT, s_val, S_W);
        settings_used++;
    endtask

    initial
    begin : stimulus
        int unsigned n_val, s_val;
        int burst, restart_pct, pick;
        bit set_n, set_s;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset geometry (16 x 32), first request with restart.
        send_request(1'b1);
        repeat (3) send_request(1'b0);

        // Below-range values saturate to 2 stacks, 3 slices: top fan,
        // bottom fan straight after, final flag, then wrap to the top.
        configure(1'b1, 0, 1'b1, 1);
        send_request(1'b1);
        repeat (7) send_request(1'b0);

        // Smallest mesh with a middle band, seam quad included.
        configure(1'b1, 3, 1'b1, 3);
        send_request(1'b1);
        repeat (12) send_request(1'b0);

        // Largest geometry, then stack and slice counts that shrink mid-fan, then over-range values.
        gap_pct = 10;
        configure(1'b1, 512, 1'b1, 1024);
        repeat (60) send_request(1'b0);
        configure(1'b1, 2, 1'b0, 0);
        repeat (40) send_request(1'b0);
        configure(1'b0, 0, 1'b1, 3);
        repeat (40) send_request(1'b0);
        configure(1'b1, 1023, 1'b1, 2047);
        send_request(1'b1);
        repeat (30) send_request(1'b0);

        // Random: mostly clean runs through whole meshes, some noisy phases.
        while (requests_sent < REQUEST_TOTAL)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                case ($urandom_range(0, 3))
                    0: n_val = 2;
                    1: n_val = 512;
                    2: n_val = $urandom_range(0, 1);
                    default: n_val = $urandom_range(513, 1023);
                endcase
                case ($urandom_range(0, 3))
                    0: s_val = 3;
                    1: s_val = 1024;
                    2: s_val = $urandom_range(0, 2);
                    default: s_val = $urandom_range(1025, 2047);
                endcase
            end
            else if (pick < 8)
            begin
                n_val = $urandom_range(2, 6);
                s_val = $urandom_range(3, 10);
            end
            else
            begin
                n_val = $urandom_range(2, 20);
                s_val = $urandom_range(3, 40);
            end
            set_n = ($urandom_range(0, 4) != 0);
            set_s = !set_n || ($urandom_range(0, 4) != 0);
            configure(set_n, n_val, set_s, s_val);

            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 10;
                default: gap_pct = 30;
            endcase
            restart_pct = ($urandom_range(0, 5) == 0) ? 30 : 2;
            burst = $urandom_range(40, 150);
            if (requests_sent >= REQUEST_TOTAL * 9 / 10)
                quiet = 1'b1;
            repeat (burst)
                send_request($urandom_range(0, 99) < restart_pct);
        end

        drain();

        $display("Summary: %0d requests under %0d register settings", requests_sent,
                 settings_used);
        $display("Summary: %0d triangles checked, %0d complete meshes", checked, meshes);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
sv/uvs_pkg.sv
sv/uvs_cfg.sv
sv/uvs_seq.sv
sv/uvs_mod.sv
sv/uvs_emit.sv
sv/uv_sphere_triangle_index_sequencer_top.sv
bench/triangle_checker.sv
bench/testbench.sv
